[src/brs_pkg.sv]
// shared constants, codes and types of the rank/select bit vector core
package brs_pkg;

    // default geometry of the store and its count index
    localparam int STORE_WORDS_DEF     = 4096;
    localparam int BLOCK_BITS_DEF      = 512;
    localparam int SUPERBLOCK_BITS_DEF = 65536;

    // fixed field widths
    localparam int WORD_W   = 64;
    localparam int ARG_W    = 19;
    localparam int ANSWER_W = 19;
    localparam int CNT_W    = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_RANK   = 2'd1,
        OP_SELECT = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

[src/brs_popcnt.sv]
// shared population count unit over a masked 64-bit word
module brs_popcnt (
    input  logic [brs_pkg::WORD_W-1:0] word,
    input  logic [brs_pkg::WORD_W-1:0] mask,
    output logic [brs_pkg::CNT_W-1:0]  count
);

    logic [63:0] bits;
    logic [1:0]  s1 [32];
    logic [2:0]  s2 [16];
    logic [3:0]  s3 [8];
    logic [4:0]  s4 [4];
    logic [5:0]  s5 [2];

    // balanced adder tree
    always_comb
    begin
        bits = word & mask;
        for (int i = 0; i < 32; i++)
        begin
            s1[i] = {1'b0, bits[2*i]} + {1'b0, bits[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        count = {1'b0, s5[0]} + {1'b0, s5[1]};
    end

endmodule

[src/brs_mem.sv]
// word store and block count memories, one write and one registered read each
module brs_mem #(
    parameter int STORE_WORDS = brs_pkg::STORE_WORDS_DEF,
    parameter int NUM_BLOCKS  = 512,
    parameter int BC_W        = 16,
    localparam int WA_W       = $clog2(STORE_WORDS),
    localparam int BA_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  logic                        clk,
    input  logic                        word_we,
    input  logic [WA_W-1:0]             word_waddr,
    input  logic [brs_pkg::WORD_W-1:0]  word_wdata,
    input  logic [WA_W-1:0]             word_raddr,
    output logic [brs_pkg::WORD_W-1:0]  word_rdata,
    input  logic                        bc_we,
    input  logic [BA_W-1:0]             bc_waddr,
    input  logic [BC_W-1:0]             bc_wdata,
    input  logic [BA_W-1:0]             bc_raddr,
    output logic [BC_W-1:0]             bc_rdata
);

    logic [brs_pkg::WORD_W-1:0] word_mem [STORE_WORDS];
    logic [BC_W-1:0]            bc_mem   [NUM_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_waddr] <= word_wdata;
        end
        word_rdata <= word_mem[word_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bc_we)
        begin
            bc_mem[bc_waddr] <= bc_wdata;
        end
        bc_rdata <= bc_mem[bc_raddr];
    end

endmodule

[src/bitvector_rank_select_core.sv]
// top level of the rank/select bit vector core: sequencer, index registers and result stage
//
// The core holds a bit vector built by appending 64-bit words (bit 63 of a word is its
// lowest position) and answers rank (ones at positions 0..pos) and select (position of
// the k-th one, counting from one) queries, or clears the store. One transaction is taken
// at a time: req_stall is high from the cycle after acceptance until the result has been
// moved into the output register, which may still hold an earlier result waiting on
// rsp_stall. All work runs through one shared 64-bit population count unit and the single
// read port of each memory, with every memory read registered before its data is used. A
// clear and every out-of-range or store-full case go straight to the result, and an append
// writes its word and its index counts. A rank adds the count before its block to the
// popcounts of the words from the start of the 512-bit block up to the queried word (1 to
// 8 words); a select binary searches the block counts (up to log2 of the number of blocks
// loaded, 9 steps for a full store), scans the words of the block found (1 to 8) and then
// halves its way to the bit. The stores come up undefined and need no clearing pass; a
// clear only resets the fill count, the total and the running block sum.
module bitvector_rank_select_core #(
    parameter int STORE_WORDS     = brs_pkg::STORE_WORDS_DEF,
    parameter int BLOCK_BITS      = brs_pkg::BLOCK_BITS_DEF,
    parameter int SUPERBLOCK_BITS = brs_pkg::SUPERBLOCK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    opcode,
    input  logic [brs_pkg::ARG_W-1:0]     query_arg,
    input  logic [brs_pkg::WORD_W-1:0]    word_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [brs_pkg::ANSWER_W-1:0]  answer,
    output logic [1:0]                    status
);

    // geometry of the count index
    localparam int WPB        = BLOCK_BITS / 64;
    localparam int WPB_LOG    = $clog2(WPB);
    localparam int BPSB       = SUPERBLOCK_BITS / BLOCK_BITS;
    localparam int WPSB       = SUPERBLOCK_BITS / 64;
    localparam int NUM_BLOCKS = (STORE_WORDS * 64 + BLOCK_BITS - 1) / BLOCK_BITS;
    localparam int NUM_SB     = (STORE_WORDS * 64 + SUPERBLOCK_BITS - 1) / SUPERBLOCK_BITS;

    // widths
    localparam int WL_W   = $clog2(STORE_WORDS + 1);
    localparam int WA_W   = $clog2(STORE_WORDS);
    localparam int BA_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SA_W   = (NUM_SB > 1) ? $clog2(NUM_SB) : 1;
    localparam int TOT_W  = $clog2(STORE_WORDS * 64 + 1);
    localparam int BC_W   = $clog2(SUPERBLOCK_BITS);
    localparam int RS_W   = BC_W + 1;
    localparam int R_W    = $clog2(BLOCK_BITS + 1);
    localparam int CMP_W  = ((WL_W + 6 > brs_pkg::ARG_W) ? WL_W + 6 : brs_pkg::ARG_W) + 1;

    // halving steps that locate one bit inside a word
    localparam int BIT_STEPS = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_APPEND,
        S_RK_BASE,
        S_RK_RD,
        S_RK_ACC,
        S_SL_MID,
        S_SL_CMP,
        S_SL_SETUP,
        S_SL_WRD,
        S_SL_WCHK,
        S_SL_BIT,
        S_FINISH
    } state_t;

    // control state
    state_t                        state_reg, state_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [brs_pkg::ANSWER_W-1:0]  answer_reg, answer_next;
    brs_pkg::status_t              status_reg, status_next;
    logic [WL_W-1:0]               words_loaded_reg, words_loaded_next;
    logic [TOT_W-1:0]              total_ones_reg, total_ones_next;
    logic [RS_W-1:0]               run_sum_reg, run_sum_next;

    // working registers of one transaction
    brs_pkg::opcode_t              op_reg, op_next;
    logic [brs_pkg::ARG_W-1:0]     arg_reg, arg_next;
    logic [brs_pkg::WORD_W-1:0]    word_reg, word_next;
    logic [BA_W-1:0]               lo_reg, lo_next;
    logic [BA_W-1:0]               hi_reg, hi_next;
    logic [BA_W-1:0]               mid_reg, mid_next;
    logic [TOT_W-1:0]              lo_base_reg, lo_base_next;
    logic [TOT_W-1:0]              sum_reg, sum_next;
    logic [WA_W-1:0]               last_reg, last_next;
    logic [WA_W-1:0]               ptr_reg, ptr_next;
    logic [WL_W-1:0]               wend_reg, wend_next;
    logic [R_W-1:0]                r_reg, r_next;
    logic [5:0]                    base_reg, base_next;
    logic [2:0]                    step_reg, step_next;
    logic [brs_pkg::ANSWER_W-1:0]  res_answer_reg, res_answer_next;
    brs_pkg::status_t              res_status_reg, res_status_next;

    // cumulative ones before each superblock
    logic [TOT_W-1:0]              sb_count_reg [NUM_SB];
    logic                          sb_we;
    logic [SA_W-1:0]               sb_waddr;
    logic [BA_W-1:0]               sb_src;
    logic [SA_W-1:0]               sb_raddr;
    logic [TOT_W-1:0]              sb_rdata;

    // memory ports
    logic                          word_we;
    logic [WA_W-1:0]               word_waddr;
    logic [WA_W-1:0]               word_raddr;
    logic [brs_pkg::WORD_W-1:0]    word_rdata;
    logic                          bc_we;
    logic [BA_W-1:0]               bc_waddr;
    logic [BC_W-1:0]               bc_wdata;
    logic [BA_W-1:0]               bc_raddr;
    logic [BC_W-1:0]               bc_rdata;

    // shared popcount unit
    logic [brs_pkg::WORD_W-1:0]    pop_word;
    logic [brs_pkg::WORD_W-1:0]    pop_mask;
    logic [brs_pkg::CNT_W-1:0]     pop_count;

    // derived values
    logic [CMP_W-1:0]              arg_ext;
    logic [CMP_W-1:0]              wl_bits;
    logic [CMP_W-1:0]              tot_ext;
    logic [BA_W-1:0]               arg_blk;
    logic [WA_W-1:0]               arg_word;
    logic [BA_W-1:0]               sel_hi;
    logic [brs_pkg::WORD_W-1:0]    rank_mask;
    logic                          sb_bound;
    logic                          blk_bound;
    logic [RS_W-1:0]               run_base;
    logic [BA_W:0]                 span;
    logic [BA_W-1:0]               mid_calc;
    logic [TOT_W-1:0]              obb;
    logic [TOT_W-1:0]              sum_add;
    logic [5:0]                    half;
    logic [5:0]                    base_new;
    logic [WA_W-1:0]               ptr_start;
    logic [WL_W:0]                 wend_cand;

    brs_popcnt u_pop (
        .word  (pop_word),
        .mask  (pop_mask),
        .count (pop_count)
    );

    brs_mem #(
        .STORE_WORDS (STORE_WORDS),
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BC_W        (BC_W)
    ) u_mem (
        .clk        (clk),
        .word_we    (word_we),
        .word_waddr (word_waddr),
        .word_wdata (word_reg),
        .word_raddr (word_raddr),
        .word_rdata (word_rdata),
        .bc_we      (bc_we),
        .bc_waddr   (bc_waddr),
        .bc_wdata   (bc_wdata),
        .bc_raddr   (bc_raddr),
        .bc_rdata   (bc_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

    // query bounds and positions
    assign arg_ext   = CMP_W'(arg_reg);
    assign wl_bits   = CMP_W'({words_loaded_reg, 6'b0});
    assign tot_ext   = CMP_W'(total_ones_reg);
    assign arg_blk   = BA_W'(arg_reg / BLOCK_BITS);
    assign arg_word  = WA_W'(arg_reg >> 6);
    assign sel_hi    = BA_W'((int'(words_loaded_reg) + WPB - 1) / WPB - 1);
    // keeps positions 0..pos of the last word, msb first
    assign rank_mask = ~(64'h7FFF_FFFF_FFFF_FFFF >> arg_reg[5:0]);

    // append boundaries
    assign sb_bound   = ((words_loaded_reg % WPSB) == 0);
    assign blk_bound  = ((words_loaded_reg % WPB) == 0);
    assign run_base   = sb_bound ? '0 : run_sum_reg;
    assign word_waddr = WA_W'(words_loaded_reg);
    assign sb_waddr   = SA_W'(words_loaded_reg / WPSB);
    assign bc_waddr   = BA_W'(words_loaded_reg / WPB);
    assign bc_wdata   = BC_W'(run_base);

    // one superblock read per cycle: the probe during search, the block base otherwise
    assign sb_src   = (state_reg == S_SL_CMP) ? mid_reg : lo_reg;
    assign sb_raddr = SA_W'(sb_src / BPSB);
    assign sb_rdata = sb_count_reg[sb_raddr];

    // shared arithmetic
    assign span      = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
    assign mid_calc  = lo_reg + BA_W'(span >> 1);
    assign obb       = sb_rdata + TOT_W'(bc_rdata);
    assign sum_add   = sum_reg + TOT_W'(pop_count);
    assign half      = 6'(32 >> step_reg);
    assign ptr_start = WA_W'(lo_reg) << WPB_LOG;
    assign wend_cand = (WL_W + 1)'(ptr_start) + (WL_W + 1)'(WPB);

    always_comb
    begin
        state_next        = state_reg;
        rsp_valid_next    = rsp_valid_reg;
        answer_next       = answer_reg;
        status_next       = status_reg;
        words_loaded_next = words_loaded_reg;
        total_ones_next   = total_ones_reg;
        run_sum_next      = run_sum_reg;
        op_next           = op_reg;
        arg_next          = arg_reg;
        word_next         = word_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        lo_base_next      = lo_base_reg;
        sum_next          = sum_reg;
        last_next         = last_reg;
        ptr_next          = ptr_reg;
        wend_next         = wend_reg;
        r_next            = r_reg;
        base_next         = base_reg;
        step_next         = step_reg;
        res_answer_next   = res_answer_reg;
        res_status_next   = res_status_reg;
        base_new          = base_reg;

        word_we    = 1'b0;
        bc_we      = 1'b0;
        sb_we      = 1'b0;
        word_raddr = ptr_reg;
        bc_raddr   = lo_reg;
        pop_word   = word_reg;
        pop_mask   = '1;

        // output register drains when the consumer takes the transaction
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = brs_pkg::opcode_t'(opcode);
                    arg_next   = query_arg;
                    word_next  = word_data;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_answer_next = '0;
                res_status_next = brs_pkg::ST_OK;
                case (op_reg)
                    brs_pkg::OP_APPEND:
                    begin
                        if (words_loaded_reg == WL_W'(STORE_WORDS))
                        begin
                            res_status_next = brs_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_APPEND;
                        end
                    end

                    brs_pkg::OP_RANK:
                    begin
                        if (arg_ext >= wl_bits)
                        begin
                            res_status_next = brs_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            lo_next    = arg_blk;
                            last_next  = arg_word;
                            bc_raddr   = arg_blk;
                            state_next = S_RK_BASE;
                        end
                    end

                    brs_pkg::OP_SELECT:
                    begin
                        if ((arg_reg == '0) || (arg_ext > tot_ext))
                        begin
                            res_status_next = brs_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            // block zero always starts at zero ones
                            lo_next      = '0;
                            hi_next      = sel_hi;
                            lo_base_next = '0;
                            state_next   = (sel_hi != '0) ? S_SL_MID : S_SL_SETUP;
                        end
                    end

                    brs_pkg::OP_CLEAR:
                    begin
                        words_loaded_next = '0;
                        total_ones_next   = '0;
                        run_sum_next      = '0;
                        state_next        = S_FINISH;
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_APPEND:
            begin
                word_we  = 1'b1;
                pop_word = word_reg;
                sb_we    = sb_bound;
                bc_we    = blk_bound;
                total_ones_next   = total_ones_reg + TOT_W'(pop_count);
                run_sum_next      = run_base + RS_W'(pop_count);
                words_loaded_next = words_loaded_reg + 1'b1;
                state_next        = S_FINISH;
            end

            S_RK_BASE:
            begin
                // block count has arrived; start at the first word of the block
                sum_next   = obb;
                ptr_next   = last_reg - WA_W'(last_reg % WPB);
                state_next = S_RK_RD;
            end

            S_RK_RD:
            begin
                state_next = S_RK_ACC;
            end

            S_RK_ACC:
            begin
                pop_word = word_rdata;
                pop_mask = (ptr_reg == last_reg) ? rank_mask : '1;
                sum_next = sum_add;
                if (ptr_reg == last_reg)
                begin
                    res_answer_next = brs_pkg::ANSWER_W'(sum_add);
                    state_next      = S_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_RK_RD;
                end
            end

            S_SL_MID:
            begin
                mid_next   = mid_calc;
                bc_raddr   = mid_calc;
                state_next = S_SL_CMP;
            end

            S_SL_CMP:
            begin
                // keep the last block whose preceding count is below k
                if (CMP_W'(obb) < arg_ext)
                begin
                    lo_next      = mid_reg;
                    lo_base_next = obb;
                end
                else
                begin
                    hi_next = mid_reg - 1'b1;
                end
                state_next = (lo_next < hi_next) ? S_SL_MID : S_SL_SETUP;
            end

            S_SL_SETUP:
            begin
                r_next   = R_W'(arg_ext - CMP_W'(lo_base_reg));
                ptr_next = ptr_start;
                if (wend_cand > {1'b0, words_loaded_reg})
                begin
                    wend_next = words_loaded_reg;
                end
                else
                begin
                    wend_next = WL_W'(wend_cand);
                end
                state_next = S_SL_WRD;
            end

            S_SL_WRD:
            begin
                state_next = S_SL_WCHK;
            end

            S_SL_WCHK:
            begin
                pop_word = word_rdata;
                if ((((WL_W + 1)'(ptr_reg) + 1'b1) < (WL_W + 1)'(wend_reg)) &&
                    (R_W'(pop_count) < r_reg))
                begin
                    r_next     = r_reg - R_W'(pop_count);
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_SL_WRD;
                end
                else
                begin
                    word_next  = word_rdata;
                    base_next  = '0;
                    step_next  = '0;
                    state_next = S_SL_BIT;
                end
            end

            S_SL_BIT:
            begin
                // count the upper half of the window, then keep the half holding the one
                pop_word = word_reg;
                pop_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> half);
                if (r_reg > R_W'(pop_count))
                begin
                    r_next    = r_reg - R_W'(pop_count);
                    base_new  = base_reg + half;
                    word_next = word_reg << half;
                end
                base_next = base_new;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'(BIT_STEPS - 1))
                begin
                    res_answer_next = brs_pkg::ANSWER_W'({ptr_reg, base_new});
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    answer_next    = res_answer_reg;
                    status_next    = res_status_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            answer_reg       <= '0;
            status_reg       <= brs_pkg::ST_OK;
            words_loaded_reg <= '0;
            total_ones_reg   <= '0;
            run_sum_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            answer_reg       <= answer_next;
            status_reg       <= status_next;
            words_loaded_reg <= words_loaded_next;
            total_ones_reg   <= total_ones_next;
            run_sum_reg      <= run_sum_next;
        end
    end

    // working registers and superblock counts
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        arg_reg        <= arg_next;
        word_reg       <= word_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        lo_base_reg    <= lo_base_next;
        sum_reg        <= sum_next;
        last_reg       <= last_next;
        ptr_reg        <= ptr_next;
        wend_reg       <= wend_next;
        r_reg          <= r_next;
        base_reg       <= base_next;
        step_reg       <= step_next;
        res_answer_reg <= res_answer_next;
        res_status_reg <= res_status_next;
        if (sb_we)
        begin
            sb_count_reg[sb_waddr] <= total_ones_reg;
        end
    end

endmodule

[src/brs_checker.sv]
// port-level checker for the rank/select bit vector core and its bind
module brs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [brs_pkg::ANSWER_W-1:0]  answer,
    input logic [1:0]                    status
);

    // a transaction taken in keeps the core busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("core took a transaction and was not busy afterwards");

    // error results never carry an answer
    a_error_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != brs_pkg::ST_OK)) |-> (answer == '0))
        else $error("error status with non-zero answer");

    // a new result only appears after the core has been busy
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without work in progress");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(answer) && $stable(status)))
        else $error("stalled result changed or dropped");

endmodule

bind bitvector_rank_select_core brs_checker u_brs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .answer    (answer),
    .status    (status)
);

[verif/tb_bitvector_rank_select_core.sv]
// self-checking testbench of the rank/select bit vector core with random handshake idling
module tb_bitvector_rank_select_core;

    localparam int     STORE_WORDS  = brs_pkg::STORE_WORDS_DEF;
    localparam int     WORD_W       = brs_pkg::WORD_W;
    localparam int     ARG_W        = brs_pkg::ARG_W;
    localparam int     ANSWER_W     = brs_pkg::ANSWER_W;
    // words loaded in the long fill, just past the first superblock boundary
    localparam int     FILL_WORDS   = 1152;
    localparam int     RANDOM_ITEMS = 600;
    // tail of the random part run with both sides always ready
    localparam int     QUIET_ITEMS  = 150;
    // quiet spell after the last reply, longer than the longest select takes to reach the output register
    localparam int     DRAIN_CYCLES = 64;
    // slowest correct run is about 2000 transactions
    localparam longint CYCLE_LIMIT  = 3000000;

    // reply awaited from the core for one accepted transaction
    typedef struct {
        logic [ANSWER_W-1:0] answer;
        brs_pkg::status_t    status;
        brs_pkg::opcode_t    op;
        logic [ARG_W-1:0]    arg;
    } reply_t;

    // shadow copy of the bit vector and the queue of replies still to come
    class rank_select_tracker;
        logic [WORD_W-1:0] shadow_words [STORE_WORDS];
        int unsigned       fill;
        int unsigned       ones;
        int unsigned       errors;
        reply_t            awaited_replies [$];

        function new();
            fill   = 0;
            ones   = 0;
            errors = 0;
        endfunction

        // work out the reply to an accepted transaction and queue it
        function void note_request(brs_pkg::opcode_t op, logic [ARG_W-1:0] arg,
                                   logic [WORD_W-1:0] word);
            reply_t      r;
            int unsigned pos;
            int unsigned left;
            int unsigned idx;
            int unsigned sum;
            int unsigned bit_off;
            r.answer = '0;
            r.status = brs_pkg::ST_OK;
            r.op     = op;
            r.arg    = arg;
            pos      = 32'(arg);
            case (op)
                brs_pkg::OP_APPEND:
                begin
                    if (fill >= STORE_WORDS)
                        r.status = brs_pkg::ST_FULL;
                    else
                    begin
                        shadow_words[fill] = word;
                        ones += $countones(word);
                        fill++;
                    end
                end
                brs_pkg::OP_RANK:
                begin
                    if (pos >= fill * 64)
                        r.status = brs_pkg::ST_RANGE;
                    else
                    begin
                        // whole words before the queried one, then the msb-first head
                        sum = 0;
                        for (idx = 0; idx < pos / 64; idx++)
                            sum += $countones(shadow_words[idx]);
                        sum += $countones(shadow_words[pos / 64] >> (63 - pos % 64));
                        r.answer = sum[ANSWER_W-1:0];
                    end
                end
                brs_pkg::OP_SELECT:
                begin
                    if (pos == 0 || pos > ones)
                        r.status = brs_pkg::ST_RANGE;
                    else
                    begin
                        left = pos;
                        idx  = 0;
                        while ($countones(shadow_words[idx]) < left)
                        begin
                            left -= $countones(shadow_words[idx]);
                            idx++;
                        end
                        sum = 0;
                        for (bit_off = 0; left != 0; bit_off++)
                        begin
                            if (shadow_words[idx][63 - bit_off])
                            begin
                                left--;
                                if (left == 0)
                                    sum = idx * 64 + bit_off;
                            end
                        end
                        r.answer = sum[ANSWER_W-1:0];
                    end
                end
                default:
                begin
                    fill = 0;
                    ones = 0;
                end
            endcase
            awaited_replies.push_back(r);
        endfunction

        // compare a delivered reply with the oldest one awaited
        function void check_reply(logic [ANSWER_W-1:0] answer, logic [1:0] status);
            reply_t want;
            if (awaited_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual answer %0d status %0d",
                         $time, answer, status);
                return;
            end
            want = awaited_replies.pop_front();
            if (answer !== want.answer)
            begin
                errors++;
                $display("%0t: %s arg %0d answer, expected %0d, actual %0d",
                         $time, want.op.name(), want.arg, want.answer, answer);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: %s arg %0d status, expected %0d, actual %0d",
                         $time, want.op.name(), want.arg, want.status, status);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [1:0]          opcode;
    logic [ARG_W-1:0]    query_arg;
    logic [WORD_W-1:0]   word_data;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [ANSWER_W-1:0] answer;
    logic [1:0]          status;

    // idling switches, toggled per phase and cleared for the tail
    logic                req_idle_en;
    logic                rsp_idle_en;
    longint              cycle_count;

    rank_select_tracker  tracker;

    bitvector_rank_select_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .query_arg (query_arg),
        .word_data (word_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .answer    (answer),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog: a hung core ends the run here
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiving side: random stall bursts while enabled, otherwise always ready
    initial
    begin
        int burst;
        burst     = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst == 0 && rsp_idle_en && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 19);
            rsp_stall <= (burst != 0);
            if (burst != 0)
                burst--;
        end
    end

    // replies are taken at the rising edge where valid is high and stall is low
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_reply(answer, status);
    end

    // word with a random density of ones, including the all-zero and all-one words
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(0, 63);
            3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
            4: w = w | {$urandom, $urandom} | {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    // rank position: mostly inside the data, sometimes at or past its end
    function automatic logic [ARG_W-1:0] rank_position(int unsigned fill);
        logic [ARG_W-1:0] p;
        case ($urandom_range(0, 9))
            0: p = ARG_W'($urandom);
            1: p = ARG_W'(fill * 64);
            2: p = ARG_W'(fill * 64 - 1);
            default: p = (fill == 0) ? ARG_W'($urandom)
                                     : ARG_W'($urandom_range(0, fill * 64 - 1));
        endcase
        return p;
    endfunction

    // select count: mostly a one that exists, sometimes zero or beyond the total
    function automatic logic [ARG_W-1:0] select_count(int unsigned ones);
        logic [ARG_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = ARG_W'($urandom);
            1: c = '0;
            2: c = ARG_W'(ones + 1);
            3: c = ARG_W'(ones);
            default: c = (ones == 0) ? ARG_W'($urandom) : ARG_W'($urandom_range(1, ones));
        endcase
        return c;
    endfunction

    // drive one transaction from a falling edge and hold it until accepted
    task automatic send_request(brs_pkg::opcode_t op, logic [ARG_W-1:0] arg,
                                logic [WORD_W-1:0] word);
        int gap;
        if (req_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        query_arg <= arg;
        word_data <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tracker.note_request(op, arg, word);
        @(negedge clk);
    endtask

    // rank or select with noise in the field the operation ignores
    task automatic send_random_query();
        if ($urandom_range(0, 1) == 0)
            send_request(brs_pkg::OP_RANK, rank_position(tracker.fill), random_word());
        else
            send_request(brs_pkg::OP_SELECT, select_count(tracker.ones), random_word());
    endtask

    initial
    begin
        int          rand_items;
        int          target;
        int          phase_len;
        int          k;
        tracker     = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        opcode      = brs_pkg::OP_APPEND;
        query_arg   = '0;
        word_data   = '0;
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: queries on an empty store
        send_request(brs_pkg::OP_RANK, '0, '0);
        send_request(brs_pkg::OP_SELECT, '0, '0);
        send_request(brs_pkg::OP_SELECT, 19'd1, '1);
        // four words: all ones, all zeros, both ends, last position only
        send_request(brs_pkg::OP_APPEND, '1, '1);
        send_request(brs_pkg::OP_APPEND, '0, '0);
        send_request(brs_pkg::OP_APPEND, 19'd5, 64'h8000_0000_0000_0001);
        send_request(brs_pkg::OP_APPEND, 19'd9, 64'h0000_0000_0000_0001);
        // rank at word edges, at the end of the data and past it
        send_request(brs_pkg::OP_RANK, 19'd0, '1);
        send_request(brs_pkg::OP_RANK, 19'd63, '0);
        send_request(brs_pkg::OP_RANK, 19'd64, '0);
        send_request(brs_pkg::OP_RANK, 19'd128, '0);
        send_request(brs_pkg::OP_RANK, 19'd255, '0);
        send_request(brs_pkg::OP_RANK, 19'd256, '0);
        send_request(brs_pkg::OP_RANK, '1, '0);
        // select of the first and last ones, across a word edge and past the total
        send_request(brs_pkg::OP_SELECT, 19'd1, '0);
        send_request(brs_pkg::OP_SELECT, 19'd64, '0);
        send_request(brs_pkg::OP_SELECT, 19'd65, '0);
        send_request(brs_pkg::OP_SELECT, 19'd67, '0);
        send_request(brs_pkg::OP_SELECT, 19'd68, '0);
        send_request(brs_pkg::OP_SELECT, '1, '1);
        // clear leaves nothing reachable
        send_request(brs_pkg::OP_CLEAR, '1, '1);
        send_request(brs_pkg::OP_RANK, 19'd0, '0);
        send_request(brs_pkg::OP_SELECT, 19'd1, '0);
        send_request(brs_pkg::OP_APPEND, ARG_W'($urandom), random_word());

        // long fill across the first superblock boundary, queries mixed in
        send_request(brs_pkg::OP_CLEAR, ARG_W'($urandom), random_word());
        for (k = 0; k < FILL_WORDS; k++)
        begin
            if (k % 512 == 0)
            begin
                req_idle_en = ($urandom_range(0, 3) != 0);
                rsp_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_request(brs_pkg::OP_APPEND, ARG_W'($urandom), random_word());
            if ($urandom_range(0, 7) == 0)
                send_random_query();
        end
        send_request(brs_pkg::OP_RANK, ARG_W'(tracker.fill * 64 - 1), random_word());
        send_request(brs_pkg::OP_RANK, ARG_W'(tracker.fill * 64), random_word());
        send_request(brs_pkg::OP_SELECT, ARG_W'(tracker.ones), random_word());
        send_request(brs_pkg::OP_SELECT, ARG_W'(tracker.ones + 1), random_word());

        // random phases: clear, then appends up to a target size mixed with queries
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            req_idle_en = (rand_items < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            rsp_idle_en = (rand_items < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            // mostly one or two blocks, now and then a few dozen blocks
            case ($urandom_range(0, 39))
                0:       target = $urandom_range(151, 400);
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                         target = $urandom_range(17, 150);
                default: target = $urandom_range(1, 16);
            endcase
            send_request(brs_pkg::OP_CLEAR, ARG_W'($urandom), random_word());
            rand_items++;
            phase_len = target + 4 + $urandom_range(0, target);
            for (k = 0; k < phase_len; k++)
            begin
                if (rand_items + k >= RANDOM_ITEMS - QUIET_ITEMS)
                begin
                    req_idle_en = 1'b0;
                    rsp_idle_en = 1'b0;
                end
                if (tracker.fill < target && $urandom_range(0, 2) != 0)
                    send_request(brs_pkg::OP_APPEND, ARG_W'($urandom), random_word());
                else if ($urandom_range(0, 39) == 0)
                    send_request(brs_pkg::OP_CLEAR, ARG_W'($urandom), random_word());
                else
                    send_random_query();
            end
            rand_items += phase_len;
        end
        req_valid <= 1'b0;

        // wait for the last replies, then a quiet spell for stray ones
        while (tracker.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/brs_pkg.sv
src/brs_popcnt.sv
src/brs_mem.sv
src/bitvector_rank_select_core.sv
src/brs_checker.sv
verif/tb_bitvector_rank_select_core.sv
